// ===== src/tve_pkg.sv =====
// ----------------------------------------------------------------------------
// tve_pkg
// Shared types, command codes and tag bytes of the tagged varint encoder.
// ----------------------------------------------------------------------------
package tve_pkg;

   // field widths
   localparam int CMD_W   = 3;
   localparam int VALUE_W = 64;
   localparam int BYTE_W  = 8;
   localparam int DIGIT_W = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_END      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_U32      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_U64      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STR_HDR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BOOL     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_STR_BYTE = 3'd5;

   // tag bytes
   localparam logic [BYTE_W-1:0] TAG_END  = 8'h00;
   localparam logic [BYTE_W-1:0] TAG_U32  = 8'h01;
   localparam logic [BYTE_W-1:0] TAG_U64  = 8'h02;
   localparam logic [BYTE_W-1:0] TAG_STR  = 8'h03;
   localparam logic [BYTE_W-1:0] TAG_BOOL = 8'h04;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TAG,
      ST_VARINT,
      ST_RAW
   } state_type;

   // tag byte of a command
   function automatic logic [BYTE_W-1:0] tag_of(input logic [CMD_W-1:0] cmd);
      logic [BYTE_W-1:0] tag;
      unique case (cmd)
         CMD_U32:     tag = TAG_U32;
         CMD_U64:     tag = TAG_U64;
         CMD_STR_HDR: tag = TAG_STR;
         CMD_BOOL:    tag = TAG_BOOL;
         default:     tag = TAG_END;
      endcase
      return tag;
   endfunction

endpackage

// ===== src/tagged_varint_encoder.sv =====
// ----------------------------------------------------------------------------
// tagged_varint_encoder
// Turns command/value transactions into a tagged byte stream with LEB128
// varints, up to one byte per cycle as the receiver takes them.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_tuser carries the command, req_tdata the 64-bit value.
//   rsp channel: one transaction per output byte, rsp_tlast on the final
//   byte of each input transaction. Commands 6 and 7 are taken and dropped.
//   A value is held in a shift register and leaves seven bits per output
//   byte: an item gives 1 byte for end or a string byte, 2 for bool, 2 to
//   6 for u32, 2 to 11 for u64 and string headers. The next request is
//   taken in the cycle that the last byte of the current one is issued, so
//   back-to-back items keep the output busy every cycle while the receiver
//   is ready. Every byte on rsp comes from the output register.
//   The output register parts the two sides: while the receiver stalls,
//   the held byte stays and the sequencer waits with it.
//   Synchronous reset clears the sequencer and the output valid; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module tagged_varint_encoder (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tve_pkg::VALUE_W-1:0]         req_tdata,  // [63:0] value
   input  logic [tve_pkg::CMD_W-1:0]           req_tuser,  // [2:0] command
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tve_pkg::BYTE_W-1:0]          rsp_tdata,  // [7:0] out_byte
   output logic                                rsp_tlast   // last
);
   import tve_pkg::*;

   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     kind_ff, kind_in;
   logic [VALUE_W-1:0]   shift_ff, shift_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_free;
   logic                 emit;
   logic                 accept;
   logic                 more;
   logic [BYTE_W-1:0]    emit_byte;
   logic                 emit_last;
   state_type            start_state;
   logic [VALUE_W-1:0]   start_value;

   // output slot and handshakes
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit       = (state_ff != ST_IDLE) && slot_free;
   assign req_tready = (state_ff == ST_IDLE) || (emit && emit_last);
   assign accept     = req_tvalid && req_tready;

   // remaining digits beyond the current one
   assign more = |shift_ff[VALUE_W-1:DIGIT_W];

   // byte issued by the current state
   always_comb begin
      emit_byte = TAG_END;
      emit_last = 1'b0;
      unique case (state_ff)
         ST_TAG: begin
            emit_byte = tag_of(kind_ff);
            emit_last = (kind_ff == CMD_END);
         end
         ST_VARINT: begin
            emit_byte = {more, shift_ff[DIGIT_W-1:0]};
            emit_last = !more;
         end
         ST_RAW: begin
            emit_byte = shift_ff[BYTE_W-1:0];
            emit_last = 1'b1;
         end
         default: begin
            emit_byte = TAG_END;
            emit_last = 1'b0;
         end
      endcase
   end

   // decode of a new transaction
   always_comb begin
      start_value = req_tdata;
      unique case (req_tuser)
         CMD_END, CMD_U64, CMD_STR_HDR: begin
            start_state = ST_TAG;
         end
         CMD_U32: begin
            start_state = ST_TAG;
            start_value = {{(VALUE_W-32){1'b0}}, req_tdata[31:0]};
         end
         CMD_BOOL: begin
            start_state = ST_TAG;
            start_value = {{(VALUE_W-1){1'b0}}, |req_tdata};
         end
         CMD_STR_BYTE: begin
            start_state = ST_RAW;
            start_value = {{(VALUE_W-BYTE_W){1'b0}}, req_tdata[BYTE_W-1:0]};
         end
         default: begin
            start_state = ST_IDLE;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = start_state;
      end else if (emit) begin
         unique case (state_ff)
            ST_TAG: begin
               if (kind_ff == CMD_END) begin
                  state_in = ST_IDLE;
               end else if (kind_ff == CMD_BOOL) begin
                  state_in = ST_RAW;
               end else begin
                  state_in = ST_VARINT;
               end
            end
            ST_VARINT: state_in = more ? ST_VARINT : ST_IDLE;
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   // value shift register and command hold
   always_comb begin
      kind_in  = kind_ff;
      shift_in = shift_ff;
      if (accept) begin
         kind_in  = req_tuser;
         shift_in = start_value;
      end else if (emit && state_ff == ST_VARINT) begin
         shift_in = {{DIGIT_W{1'b0}}, shift_ff[VALUE_W-1:DIGIT_W]};
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      shift_ff    <= shift_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tagged_varint_encoder. Command/value transactions
// are driven from a queue of pending items, every accepted request is
// encoded into the bytes it should produce, and each response transaction
// is checked against the oldest of them, byte and tlast alike. Both sides
// idle at random, apart from one calm stretch in the middle of the run.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tve_pkg::*;

   // command codes that the encoder takes and drops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic [BYTE_W-1:0] MORE_BIT   = 8'h80;
   localparam int                RANDOM_ITEMS = 450;
   localparam int                IDLE_PCT     = 33;
   localparam int                STALL_LIMIT  = 2000;
   localparam int                TAIL_CYCLES  = 20;
   localparam int                CALM_FROM    = 700;
   localparam int                CALM_TO      = 1100;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      bit                 wait_drain;  // hold until all owed bytes are out
   } request_type;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [VALUE_W-1:0]   req_tdata  = '0;  // [63:0] value
   logic [CMD_W-1:0]     req_tuser  = '0;  // [2:0] command
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [BYTE_W-1:0]    rsp_tdata;        // [7:0] out_byte
   logic                 rsp_tlast;        // last

   request_type     pending_items[$];
   stream_byte_type owed_bytes[$];
   int              bytes_seen   = 0;
   int              mismatches   = 0;
   int              quiet_cycles = 0;

   tagged_varint_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // no idling on either side while the calm stretch lasts
   function automatic bit busy_now();
      if (bytes_seen >= CALM_FROM && bytes_seen < CALM_TO) begin
         return 1'b1;
      end
      return $urandom_range(0, 99) >= IDLE_PCT;
   endfunction

   // bytes that one request turns into, appended to the owed stream
   function automatic void encode_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
      logic [BYTE_W-1:0]  seq[$];
      logic [VALUE_W-1:0] rest;
      bit                 has_varint;
      has_varint = 1'b0;
      rest       = value;
      case (cmd)
         CMD_END: begin
            seq.push_back(TAG_END);
         end
         CMD_U32: begin
            seq.push_back(TAG_U32);
            rest       = {32'd0, value[31:0]};
            has_varint = 1'b1;
         end
         CMD_U64: begin
            seq.push_back(TAG_U64);
            has_varint = 1'b1;
         end
         CMD_STR_HDR: begin
            seq.push_back(TAG_STR);
            has_varint = 1'b1;
         end
         CMD_BOOL: begin
            seq.push_back(TAG_BOOL);
            seq.push_back((value != '0) ? 8'h01 : 8'h00);
         end
         CMD_STR_BYTE: begin
            seq.push_back(value[7:0]);
         end
         default: ;
      endcase
      // seven bits per byte, low group first, continuation on all but the last
      if (has_varint) begin
         while (rest >= VALUE_W'(MORE_BIT)) begin
            seq.push_back({1'b1, rest[6:0]});
            rest = rest >> DIGIT_W;
         end
         seq.push_back(rest[7:0]);
      end
      foreach (seq[i]) begin
         owed_bytes.push_back('{data: seq[i], last: (i == seq.size() - 1)});
      end
   endfunction

   function automatic void queue_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                         bit wait_drain = 1'b0);
      pending_items.push_back('{cmd: cmd, value: value, wait_drain: wait_drain});
   endfunction

   // random number with a random significant length
   function automatic logic [VALUE_W-1:0] rand_value();
      logic [VALUE_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return v >> $urandom_range(0, VALUE_W - 1);
      endcase
   endfunction

   // driver: next pending item once the current one is taken
   always @(posedge clock) begin
      request_type nxt;
      bit          send;
      send = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() > 0 && busy_now()) begin
            if (!pending_items[0].wait_drain || (!req_tvalid && owed_bytes.size() == 0)) begin
               nxt  = pending_items.pop_front();
               send = 1'b1;
            end
         end
         req_tvalid <= send;
         if (send) begin
            req_tdata <= nxt.value;
            req_tuser <= nxt.cmd;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= busy_now();
      end
   end

   // monitor: predict on request transactions, check response transactions
   always @(posedge clock) begin
      stream_byte_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            encode_request(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            bytes_seen++;
            if (owed_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected byte %h last %b", $realtime, rsp_tdata, rsp_tlast);
               end
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: byte %0d expected %h last %b, got %h last %b", $realtime,
                              bytes_seen, want.data, want.last, rsp_tdata, rsp_tlast);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               made;
      int               pick;
      int               len;
      bit               mid_drain_done;
      made           = 0;
      mid_drain_done = 1'b0;

      // directed: tag edges, varint length boundaries, dropped bits
      queue_request(CMD_END, '0);
      queue_request(CMD_U32, '0);
      queue_request(CMD_U32, 64'd127);
      queue_request(CMD_U32, 64'd128);
      queue_request(CMD_U32, 64'h0000_0000_FFFF_FFFF);
      queue_request(CMD_U32, 64'hFFFF_FFFF_0000_0080);
      queue_request(CMD_U32, '1);
      queue_request(CMD_U64, '0);
      queue_request(CMD_U64, '1);
      queue_request(CMD_U64, 64'h8000_0000_0000_0000);
      queue_request(CMD_U64, 64'h0000_0000_0000_3FFF);
      queue_request(CMD_STR_HDR, '0);
      queue_request(CMD_STR_HDR, 64'd300);
      queue_request(CMD_STR_HDR, '1);
      queue_request(CMD_BOOL, '0);
      queue_request(CMD_BOOL, 64'd1);
      queue_request(CMD_BOOL, 64'h8000_0000_0000_0000);
      queue_request(CMD_STR_BYTE, 64'hFF);
      queue_request(CMD_STR_BYTE, 64'hFFFF_FFFF_FFFF_FF00);
      queue_request(CMD_STR_BYTE, '1);
      queue_request(CMD_SPARE_LO, '1);
      queue_request(CMD_SPARE_HI, 64'h5A5A_5A5A_A5A5_A5A5);
      queue_request(CMD_END, '1);

      // random: mostly well-formed messages, some stray bytes and spare codes
      while (made < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            queue_request($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO, rand_value());
            continue;
         end
         if (pick < 22) begin
            len = $urandom_range(0, 6);
            queue_request(CMD_STR_HDR, $urandom_range(0, 9) == 0 ? rand_value() : VALUE_W'(len),
                          made == 0 || (!mid_drain_done && made >= 220));
            if (made >= 220) mid_drain_done = 1'b1;
            repeat (len) queue_request(CMD_STR_BYTE, {$urandom, $urandom});
            made += 1 + len;
         end else begin
            if (pick < 42)      queue_request(CMD_U32, rand_value(), made == 0);
            else if (pick < 62) queue_request(CMD_U64, rand_value(), made == 0);
            else if (pick < 76) queue_request(CMD_BOOL,
                                              $urandom_range(0, 1) ? '0 : rand_value(),
                                              made == 0);
            else if (pick < 88) queue_request(CMD_END, rand_value(), made == 0);
            else                queue_request(CMD_STR_BYTE, {$urandom, $urandom}, made == 0);
            made++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid || owed_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && owed_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
